// ----- sv/spam_pkg.sv -----
// Shared types and constants for the sparse polynomial add/multiply block.
`default_nettype none
package spam_pkg;
    localparam int unsigned MaxTermsDefault = 8;
    localparam int unsigned StoreDepth      = 8;
    localparam int unsigned TableDepth      = 64;
    localparam int unsigned CoeffW          = 16;
    localparam int unsigned ExpW            = 8;
    localparam int unsigned ResCoeffW       = 38;
    localparam int unsigned ResExpW         = 9;
    localparam int unsigned SIdxW           = 3;
    localparam int unsigned SCntW           = 4;
    localparam int unsigned TIdxW           = 6;
    localparam int unsigned TCntW           = 7;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_MUL = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ADD_RD,
        ST_ADD_DO,
        ST_MUL_RD,
        ST_MUL_PROD,
        ST_MUL_SRD,
        ST_MUL_SCMP,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             load_a;
        logic             load_b;
        logic [SIdxW-1:0] store_idx;
        logic [SIdxW-1:0] rd_i;
        logic [SIdxW-1:0] rd_j;
        logic             add_wr;
        logic [1:0]       add_pick;   // 0 both, 1 first, 2 second
        logic             prod_calc;
        logic             tbl_rd;
        logic [TIdxW-1:0] tbl_rd_addr;
        logic             tbl_wr_new;
        logic             tbl_wr_acc;
        logic [TIdxW-1:0] tbl_wr_addr;
        logic             out_load;
        logic             out_empty;
        logic             out_last;
        logic             out_ovf;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [ExpW-1:0]    exp_a;
        logic [ExpW-1:0]    exp_b;
        logic [ResExpW-1:0] prod_exp;
        logic [ResExpW-1:0] tbl_exp;
    } t_stat;
endpackage
`default_nettype wire

// ----- sv/sparse_polynomial_add_multiply.sv -----
// Top level of the sparse polynomial add/multiply block.
// Load items are accepted one per cycle. A finish item starts a job: add mode merges
// the stored terms one result term per cycle, then goes to output; multiply mode forms
// each product, then compares it against the table entries in turn by exponent, adds
// it to a matching entry or else appends it as a new entry (up to 64 products, table
// of up to 64 entries). Output starts with a table read state, then each result is
// loaded into a one-entry output register and held there until the sink takes it.
// No new request is accepted until the last result of a job has been taken.
// Operation mode is sampled at finish.
`default_nettype none
module sparse_polynomial_add_multiply
    import spam_pkg::*;
#(
    parameter int unsigned MaxTerms = MaxTermsDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,   // operation_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // poly_select, has_term, term_coeff, term_exp, finish
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // result_coeff, result_exp, term_valid
    output logic             m_axis_tlast,  // last_term
    output logic             m_axis_tuser   // overflow
);
    t_cmd  cmd;
    t_stat stat;
    logic [ResCoeffW-1:0] res_c;
    logic [ResExpW-1:0]   res_e;
    logic                 res_v;

    spam_ctrl #(.MaxTerms(MaxTerms)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode_we  (i_cfg_we),
        .i_mode     (i_cfg_wdata),
        .i_in_fire  (s_axis_tvalid & s_axis_tready),
        .i_sel      (s_axis_tdata[0]),
        .i_has      (s_axis_tdata[1]),
        .i_fin      (s_axis_tdata[26]),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready)
    );

    spam_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_coeff    (s_axis_tdata[17:2]),
        .i_exp      (s_axis_tdata[25:18]),
        .o_stat     (stat),
        .o_res_coeff(res_c),
        .o_res_exp  (res_e),
        .o_valid_t  (res_v),
        .o_last     (m_axis_tlast),
        .o_ovf      (m_axis_tuser)
    );

    assign m_axis_tdata = {res_v, res_e, res_c};
endmodule
`default_nettype wire

// ----- sv/spam_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module spam_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sv/spam_dp.sv -----
// Datapath: term stores, product unit, work table and output register.
`default_nettype none
module spam_dp
    import spam_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire t_cmd                 i_cmd,
    input  wire logic [CoeffW-1:0]    i_coeff,
    input  wire logic [ExpW-1:0]      i_exp,
    output t_stat                     o_stat,
    output logic [ResCoeffW-1:0]      o_res_coeff,
    output logic [ResExpW-1:0]        o_res_exp,
    output logic                      o_valid_t,
    output logic                      o_last,
    output logic                      o_ovf
);
    logic signed [CoeffW-1:0] r_ca [StoreDepth];
    logic [ExpW-1:0]          r_ea [StoreDepth];
    logic signed [CoeffW-1:0] r_cb [StoreDepth];
    logic [ExpW-1:0]          r_eb [StoreDepth];
    logic signed [CoeffW-1:0] ca, cb;
    logic signed [ResCoeffW-1:0] r_pc;
    logic [ResExpW-1:0]       r_pe;
    logic                     tbl_we;
    logic [TIdxW-1:0]         tbl_waddr;
    logic [TIdxW-1:0]         tbl_raddr;
    logic [ResCoeffW+ResExpW-1:0] tbl_wdata, tbl_rdata;
    logic signed [ResCoeffW-1:0] tbl_c, add_c;
    logic [ResExpW-1:0]       add_e;

    // store loaded terms
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_ca[i_cmd.store_idx] <= i_coeff;
            r_ea[i_cmd.store_idx] <= i_exp;
        end
        if (i_cmd.load_b) begin
            r_cb[i_cmd.store_idx] <= i_coeff;
            r_eb[i_cmd.store_idx] <= i_exp;
        end
    end

    assign ca = r_ca[i_cmd.rd_i];
    assign cb = r_cb[i_cmd.rd_j];

    // registered pairwise product
    always_ff @(posedge i_clk) begin
        if (i_cmd.prod_calc) begin
            r_pc <= ResCoeffW'(ca * cb);
            r_pe <= ResExpW'(r_ea[i_cmd.rd_i]) + ResExpW'(r_eb[i_cmd.rd_j]);
        end
    end

    assign tbl_c = tbl_rdata[ResCoeffW+ResExpW-1:ResExpW];

    // add-mode merge term
    always_comb begin
        case (i_cmd.add_pick)
            2'd0:    begin add_c = ResCoeffW'(ca) + ResCoeffW'(cb);
                           add_e = ResExpW'(r_ea[i_cmd.rd_i]); end
            2'd1:    begin add_c = ResCoeffW'(ca); add_e = ResExpW'(r_ea[i_cmd.rd_i]); end
            default: begin add_c = ResCoeffW'(cb); add_e = ResExpW'(r_eb[i_cmd.rd_j]); end
        endcase
    end

    // table write select
    always_comb begin
        tbl_we    = i_cmd.add_wr | i_cmd.tbl_wr_new | i_cmd.tbl_wr_acc;
        tbl_waddr = i_cmd.tbl_wr_addr;
        if (i_cmd.add_wr) begin
            tbl_wdata = {add_c, add_e};
        end else if (i_cmd.tbl_wr_acc) begin
            tbl_wdata = {tbl_c + r_pc, r_pe};
        end else begin
            tbl_wdata = {r_pc, r_pe};
        end
    end
    assign tbl_raddr = i_cmd.tbl_rd_addr;

    spam_ram #(.Width(ResCoeffW + ResExpW), .Depth(TableDepth)) u_tbl (
        .i_clk  (i_clk),
        .i_we   (tbl_we),
        .i_waddr(tbl_waddr),
        .i_wdata(tbl_wdata),
        .i_raddr(tbl_raddr),
        .o_rdata(tbl_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_res_coeff <= i_cmd.out_empty ? '0 : tbl_c;
            o_res_exp   <= i_cmd.out_empty ? '0 : tbl_rdata[ResExpW-1:0];
            o_valid_t   <= ~i_cmd.out_empty;
            o_last      <= i_cmd.out_last;
            o_ovf       <= i_cmd.out_ovf;
        end
    end

    assign o_stat.exp_a    = r_ea[i_cmd.rd_i];
    assign o_stat.exp_b    = r_eb[i_cmd.rd_j];
    assign o_stat.prod_exp = r_pe;
    assign o_stat.tbl_exp  = tbl_rdata[ResExpW-1:0];
endmodule
`default_nettype wire

// ----- sv/spam_ctrl.sv -----
// Controller: load counting, merge/multiply sequencing and output handshake.
`default_nettype none
module spam_ctrl
    import spam_pkg::*;
#(
    parameter int unsigned MaxTerms = MaxTermsDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_mode_we,
    input  wire logic i_mode,
    input  wire logic i_in_fire,
    input  wire logic i_sel,
    input  wire logic i_has,
    input  wire logic i_fin,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready
);
    t_state r_state, n_state;
    logic [SCntW-1:0] r_na, n_na, r_nb, n_nb;
    logic [SCntW-1:0] r_i, n_i, r_j, n_j;
    logic [TCntW-1:0] r_k, n_k, r_n, n_n, r_m, n_m;
    logic r_ovf, n_ovf, r_mode, r_ovf_job, n_ovf_job;
    logic store_ok;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_na <= '0; r_nb <= '0; r_i <= '0; r_j <= '0;
            r_k <= '0; r_n <= '0; r_m <= '0;
            r_ovf <= 1'b0; r_ovf_job <= 1'b0; r_mode <= MODE_ADD;
        end else begin
            r_state <= n_state;
            r_na <= n_na; r_nb <= n_nb; r_i <= n_i; r_j <= n_j;
            r_k <= n_k; r_n <= n_n; r_m <= n_m;
            r_ovf <= n_ovf; r_ovf_job <= n_ovf_job;
            if (i_mode_we) begin
                r_mode <= i_mode;
            end
        end
    end

    assign store_ok = i_sel ? (r_nb < SCntW'(MaxTerms)) : (r_na < SCntW'(MaxTerms));

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_na = r_na; n_nb = r_nb; n_i = r_i; n_j = r_j;
        n_k = r_k; n_n = r_n; n_m = r_m; n_ovf = r_ovf; n_ovf_job = r_ovf_job;
        o_cmd = '0;
        o_cmd.store_idx   = i_sel ? r_nb[SIdxW-1:0] : r_na[SIdxW-1:0];
        o_cmd.rd_i        = r_i[SIdxW-1:0];
        o_cmd.rd_j        = r_j[SIdxW-1:0];
        o_cmd.tbl_wr_addr = r_k[TIdxW-1:0];
        o_cmd.tbl_rd_addr = r_n[TIdxW-1:0];
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    if (i_has) begin
                        if (store_ok) begin
                            o_cmd.load_a = ~i_sel;
                            o_cmd.load_b = i_sel;
                            if (i_sel) n_nb = r_nb + 1'b1;
                            else       n_na = r_na + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (i_fin) begin
                        n_ovf_job = (i_has && !store_ok) | r_ovf;
                        n_i = '0; n_j = '0; n_k = '0; n_n = '0; n_m = '0;
                        n_state = (r_mode == MODE_MUL) ? ST_MUL_RD : ST_ADD_DO;
                    end
                end
            end
            ST_ADD_DO: begin
                if (r_i < r_na && r_j < r_nb) begin
                    o_cmd.add_wr = 1'b1;
                    if (i_stat.exp_a == i_stat.exp_b) begin
                        o_cmd.add_pick = 2'd0; n_i = r_i + 1'b1; n_j = r_j + 1'b1;
                    end else if (i_stat.exp_a > i_stat.exp_b) begin
                        o_cmd.add_pick = 2'd1; n_i = r_i + 1'b1;
                    end else begin
                        o_cmd.add_pick = 2'd2; n_j = r_j + 1'b1;
                    end
                    n_k = r_k + 1'b1;
                end else if (r_i < r_na) begin
                    o_cmd.add_wr = 1'b1; o_cmd.add_pick = 2'd1;
                    n_i = r_i + 1'b1; n_k = r_k + 1'b1;
                end else if (r_j < r_nb) begin
                    o_cmd.add_wr = 1'b1; o_cmd.add_pick = 2'd2;
                    n_j = r_j + 1'b1; n_k = r_k + 1'b1;
                end else begin
                    n_state = ST_OUT_RD;
                end
            end
            ST_MUL_RD: begin
                if (r_i >= r_na || r_nb == '0) begin
                    n_state = ST_OUT_RD;
                end else begin
                    o_cmd.prod_calc = 1'b1;
                    n_n = '0;
                    n_state = ST_MUL_PROD;
                end
            end
            ST_MUL_PROD: begin
                n_state = ST_MUL_SRD;
            end
            ST_MUL_SRD: begin
                // search the table for a matching exponent
                if (r_n >= r_k) begin
                    o_cmd.tbl_wr_new = (r_k < TCntW'(TableDepth));
                    if (r_k < TCntW'(TableDepth)) n_k = r_k + 1'b1;
                    n_state = ST_MUL_RD;
                    if (r_j + 1'b1 >= r_nb) begin n_j = '0; n_i = r_i + 1'b1; end
                    else n_j = r_j + 1'b1;
                end else begin
                    n_state = ST_MUL_SCMP;
                end
            end
            ST_MUL_SCMP: begin
                if (i_stat.tbl_exp == i_stat.prod_exp) begin
                    o_cmd.tbl_wr_acc  = 1'b1;
                    o_cmd.tbl_wr_addr = r_n[TIdxW-1:0];
                    n_state = ST_MUL_RD;
                    if (r_j + 1'b1 >= r_nb) begin n_j = '0; n_i = r_i + 1'b1; end
                    else n_j = r_j + 1'b1;
                end else begin
                    n_n = r_n + 1'b1;
                    o_cmd.tbl_rd_addr = n_n[TIdxW-1:0];
                    n_state = ST_MUL_SRD;
                end
            end
            ST_OUT_RD: begin
                o_cmd.tbl_rd_addr = r_m[TIdxW-1:0];
                n_state = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                o_cmd.out_load  = 1'b1;
                o_cmd.out_empty = (r_k == '0);
                o_cmd.out_last  = (r_k == '0) || (r_m + 1'b1 == r_k);
                o_cmd.out_ovf   = r_ovf_job;
                n_state = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                o_out_valid = 1'b1;
                o_cmd.tbl_rd_addr = n_m[TIdxW-1:0];
                if (i_out_ready) begin
                    if (r_k == '0 || r_m + 1'b1 == r_k) begin
                        n_na = '0; n_nb = '0; n_ovf = 1'b0;
                        n_state = ST_LOAD;
                    end else begin
                        n_m = r_m + 1'b1;
                        o_cmd.tbl_rd_addr = n_m[TIdxW-1:0];
                        n_state = ST_OUT_WAIT;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
        // keep the table read aimed at the search pointer during the search
        if (r_state == ST_MUL_PROD) o_cmd.tbl_rd_addr = '0;
    end
endmodule
`default_nettype wire
